>>> hdl/ftm_pkg.sv
// ----------------------------------------------------------------------------
// ftm_pkg
// shared types, constants and helpers for the filmic tone-mapping unit
// ----------------------------------------------------------------------------
`default_nettype none

package ftm_pkg;

  // default internal fraction width
  localparam int unsigned FTM_FRACTION_BITS = 16;

  // input pixel request: unsigned 8.16 radiance per channel
  typedef struct packed {
    logic [23:0] red_in;
    logic [23:0] green_in;
    logic [23:0] blue_in;
  } ftm_in_t;

  // output pixel request: unsigned 0.16 display value per channel
  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } ftm_out_t;

  // constant given in thousandths, rounded half up to fb fraction bits
  function automatic longint unsigned fx_const(input int unsigned milli,
                                               input int unsigned fb);
    return ((64'(milli) << fb) + 64'd500) / 64'd1000;
  endfunction

endpackage

`default_nettype wire

>>> hdl/filmic_tonemap_rgb_unit.sv
// ----------------------------------------------------------------------------
// filmic_tonemap_rgb_unit
// ACES filmic tone curve on one RGB pixel per clock unless stalled. Each
// channel is scaled by the exposure 0.6, clamped to 16.0, passed through the
// rational curve x(2.51x+0.03)/(x(2.43x+0.59)+0.14) and saturated to an
// unsigned 0.16 display value. The unit takes one pixel in every cycle while
// the output is not stalled, through FRACTION_BITS+6 register stages (22 at
// the default): four stages for exposure, clamp and the two polynomial
// products, one stage that forms numerator and denominator, a restoring
// divider that settles one quotient bit per stage over FRACTION_BITS stages,
// then the output register. The whole pipeline holds while a finished result
// is not taken; in_ready is low only then. There is no state beyond the
// pipeline and nothing to configure.
// ----------------------------------------------------------------------------
`default_nettype none

module filmic_tonemap_rgb_unit #(
  parameter int unsigned FRACTION_BITS = ftm_pkg::FTM_FRACTION_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ftm_pkg::ftm_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ftm_pkg::ftm_out_t     out_data
);

  import ftm_pkg::*;

  localparam int unsigned FB   = FRACTION_BITS;
  localparam int unsigned XW   = FB + 8;        // input at FB fraction bits
  localparam int unsigned PEW  = 2 * FB + 8;    // exposure product
  localparam int unsigned VW   = FB + 5;        // clamped value, up to 16.0
  localparam int unsigned KW   = FB + 2;        // coefficients, below 4.0
  localparam int unsigned PAW  = KW + VW;       // first-order products
  localparam int unsigned TW   = FB + 6;        // linear terms, below 64.0
  localparam int unsigned PNW  = VW + TW;       // second-order products
  localparam int unsigned NW   = FB + 10;       // numerator / denominator
  localparam int unsigned RW   = NW + 1;        // doubled remainder
  localparam int unsigned NSTG = FB + 6;        // total pipeline stages

  localparam logic [KW-1:0] K_EXP = KW'(fx_const(600, FB));
  localparam logic [KW-1:0] K_A   = KW'(fx_const(2510, FB));
  localparam logic [KW-1:0] K_B   = KW'(fx_const(30, FB));
  localparam logic [KW-1:0] K_C   = KW'(fx_const(2430, FB));
  localparam logic [KW-1:0] K_D   = KW'(fx_const(590, FB));
  localparam logic [KW-1:0] K_E   = KW'(fx_const(140, FB));
  localparam logic [VW-1:0] V_MAX = {5'b10000, {FB{1'b0}}};

  // pipeline advance: hold only while a result waits at the output
  logic adv;
  logic [NSTG-1:0] vld_r;

  assign adv       = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NSTG-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // lane view of the input request
  logic [23:0] raw [3];

  always_comb begin
    raw[0] = in_data.red_in;
    raw[1] = in_data.green_in;
    raw[2] = in_data.blue_in;
  end

  // stage registers, one lane per channel
  logic [PEW-1:0] pexp_r [3];
  logic [VW-1:0]  v2_r   [3];
  logic [VW-1:0]  v3_r   [3];
  logic [PAW-1:0] pa_r   [3];
  logic [PAW-1:0] pc_r   [3];
  logic [PNW-1:0] pn_r   [3];
  logic [PNW-1:0] pd_r   [3];
  logic [NW-1:0]  rem_r  [FB+1][3];
  logic [NW-1:0]  dd_r   [FB+1][3];
  logic [FB-1:0]  q_r    [FB+1][3];
  logic           sat_r  [FB+1][3];
  ftm_out_t       out_r;

  // next values
  logic [PEW-1:0] pexp_nxt [3];
  logic [VW-1:0]  v2_nxt   [3];
  logic [PAW-1:0] pa_nxt   [3];
  logic [PAW-1:0] pc_nxt   [3];
  logic [PNW-1:0] pn_nxt   [3];
  logic [PNW-1:0] pd_nxt   [3];
  logic [NW-1:0]  num_nxt  [3];
  logic [NW-1:0]  den_nxt  [3];
  logic [NW-1:0]  rem_nxt  [FB+1][3];
  logic [FB-1:0]  q_nxt    [FB+1][3];
  ftm_out_t       out_nxt;

  // front stages: exposure, clamp, first and second order products
  always_comb begin
    logic [FB+23:0] xs;
    logic [XW-1:0]  x;
    logic [PEW-1:0] vfull;
    logic [TW-1:0]  sa;
    logic [TW-1:0]  sc;
    for (int l = 0; l < 3; l++) begin
      // bring the 16 fraction bits of the input to FB
      xs          = {raw[l], {FB{1'b0}}} >> 16;
      x           = xs[XW-1:0];
      pexp_nxt[l] = PEW'(x) * PEW'(K_EXP);
      // drop fraction and clamp to 16.0
      vfull = pexp_r[l] >> FB;
      if (vfull > PEW'(V_MAX)) begin
        v2_nxt[l] = V_MAX;
      end else begin
        v2_nxt[l] = vfull[VW-1:0];
      end
      pa_nxt[l] = PAW'(K_A) * PAW'(v2_r[l]);
      pc_nxt[l] = PAW'(K_C) * PAW'(v2_r[l]);
      // linear terms then the outer products
      sa        = TW'(pa_r[l] >> FB) + TW'(K_B);
      sc        = TW'(pc_r[l] >> FB) + TW'(K_D);
      pn_nxt[l] = PNW'(v3_r[l]) * PNW'(sa);
      pd_nxt[l] = PNW'(v3_r[l]) * PNW'(sc);
      num_nxt[l] = NW'(pn_r[l] >> FB);
      den_nxt[l] = NW'(pd_r[l] >> FB) + NW'(K_E);
    end
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    logic [RW-1:0] t;
    for (int l = 0; l < 3; l++) begin
      rem_nxt[0][l] = num_nxt[l];
      q_nxt[0][l]   = '0;
    end
    for (int k = 1; k <= FB; k++) begin
      for (int l = 0; l < 3; l++) begin
        t = {rem_r[k-1][l], 1'b0};
        if (t >= RW'(dd_r[k-1][l])) begin
          rem_nxt[k][l] = NW'(t - RW'(dd_r[k-1][l]));
          q_nxt[k][l]   = {q_r[k-1][l][FB-2:0], 1'b1};
        end else begin
          rem_nxt[k][l] = t[NW-1:0];
          q_nxt[k][l]   = {q_r[k-1][l][FB-2:0], 1'b0};
        end
      end
    end
  end

  // quotient to 0.16, saturating when the curve reaches 1.0
  always_comb begin
    logic [FB+15:0] qx;
    logic [15:0]    r16 [3];
    for (int l = 0; l < 3; l++) begin
      qx = {q_r[FB][l], 16'h0000};
      if (sat_r[FB][l]) begin
        r16[l] = 16'hFFFF;
      end else begin
        r16[l] = qx[FB+15:FB];
      end
    end
    out_nxt.red_out   = r16[0];
    out_nxt.green_out = r16[1];
    out_nxt.blue_out  = r16[2];
  end

  // payload registers, moved on advance
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        pexp_r[l]   <= pexp_nxt[l];
        v2_r[l]     <= v2_nxt[l];
        v3_r[l]     <= v2_r[l];
        pa_r[l]     <= pa_nxt[l];
        pc_r[l]     <= pc_nxt[l];
        pn_r[l]     <= pn_nxt[l];
        pd_r[l]     <= pd_nxt[l];
        rem_r[0][l] <= rem_nxt[0][l];
        q_r[0][l]   <= q_nxt[0][l];
        dd_r[0][l]  <= den_nxt[l];
        sat_r[0][l] <= (num_nxt[l] >= den_nxt[l]);
        for (int k = 1; k <= FB; k++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          q_r[k][l]   <= q_nxt[k][l];
          dd_r[k][l]  <= dd_r[k-1][l];
          sat_r[k][l] <= sat_r[k-1][l];
        end
      end
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

>>> hdl/ftm_checker.sv
// ----------------------------------------------------------------------------
// ftm_checker
// port-level checks on the filmic tone-mapping unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ftm_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire ftm_pkg::ftm_out_t out_data
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result request dropped or changed while stalled");

  // the pipeline stalls exactly when a result waits untaken
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result request right after reset");

endmodule

bind filmic_tonemap_rgb_unit ftm_checker u_ftm_checker (.*);

`default_nettype wire
